// ----- sv/weight_map_stochastic_cull_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the weight map stochastic cull unit
// Shorthand for clocked implications that use the local clk and rst.
// ----------------------------------------------------------------------------
`ifndef WEIGHT_MAP_STOCHASTIC_CULL_UNIT_MACROS_SVH
`define WEIGHT_MAP_STOCHASTIC_CULL_UNIT_MACROS_SVH

// Same-cycle implication.
`define WMSC_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define WMSC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/wmsc_pkg.sv -----
// ----------------------------------------------------------------------------
// wmsc_pkg
// Shared constants, codes and types of the weight map stochastic cull unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wmsc_pkg;

  localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [24:0] WEIGHT_ONE = 25'h1000000;
  localparam logic [39:0] ROUND_HALF = 40'd32640;
  // Low part of ceil(2^40 / 255); the full reciprocal is 2^32 plus this.
  localparam logic [24:0] RECIP_255_LO = 25'h1010102;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  localparam logic [3:0] CFG_RANGE_MIN_X     = 4'd0;
  localparam logic [3:0] CFG_RANGE_MIN_Z     = 4'd1;
  localparam logic [3:0] CFG_INV_SPAN_X      = 4'd2;
  localparam logic [3:0] CFG_INV_SPAN_Z      = 4'd3;
  localparam logic [3:0] CFG_FLIP_V          = 4'd4;
  localparam logic [3:0] CFG_IMAGE_WIDTH     = 4'd5;
  localparam logic [3:0] CFG_IMAGE_HEIGHT    = 4'd6;
  localparam logic [3:0] CFG_GENERATED_COUNT = 4'd7;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } fmix_en_t;

  function automatic logic [7:0] chan_byte(input logic [31:0] word, input logic [1:0] ch);
    logic [7:0] b;
    case (ch)
      2'd0: b = word[7:0];
      2'd1: b = word[15:8];
      2'd2: b = word[23:16];
      default: b = word[31:24];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- sv/weight_map_stochastic_cull_unit.sv -----
// ----------------------------------------------------------------------------
// weight_map_stochastic_cull_unit
// Texel loading, bilinear control-map sampling and hash-threshold culling.
//
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   kind ... has_layer
// result    out        result_valid/result_stall keep, weight, culled_count,
//                                                over_budget
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item enters per cycle while item_stall is low.
// The texel memory is duplicated so that the four bilinear taps are read in
// the same cycle through two read ports per copy; it has no clearing pass.
// Reset clears the valid bits, cull counter and over_budget; config gets defaults.
// A stalled result holds the full stages behind it up to the first empty one.
// ----------------------------------------------------------------------------
`default_nettype none

module weight_map_stochastic_cull_unit import wmsc_pkg::*; #(
  parameter int MAX_WIDTH = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int GROUPS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               kind,
  input  logic        [15:0] texel_address,
  input  logic        [31:0] texel_data,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_z,
  input  logic        [63:0] instance_id,
  input  logic        [31:0] instance_seed,
  input  logic         [3:0] layer_index,
  input  logic               has_layer,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               keep,
  output logic        [24:0] weight,
  output logic        [31:0] culled_count,
  output logic               over_budget,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic         [3:0] cfg_index,
  input  logic        [31:0] cfg_data
);

  localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
  localparam int MEM_DEPTH = GROUPS * PLANE;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int XW = 33 + CW;
  localparam int YW = 33 + RW;
  localparam int NS = 13;
  localparam logic [32:0] ONE_Q32 = 33'h100000000;

  typedef struct packed {
    logic       kind;
    logic       has;
    logic [3:0] layer;
  } tag_t;

  logic signed [31:0] range_min_x;
  logic signed [31:0] range_min_z;
  logic        [31:0] inv_span_x;
  logic        [31:0] inv_span_z;
  logic               flip_v;
  logic         [7:0] image_width;
  logic         [7:0] image_height;
  logic        [31:0] generated_count;

  logic [NS:1] v;
  logic [NS:1] rdy;
  fmix_en_t    fen;

  logic [31:0] w_full;
  logic [31:0] h_full;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;

  tag_t tag1, tag2, tag3, tag4, tag5, tag6, tag7, tag8, tag9, tag10, tag11;
  logic [AW-1:0] wa1, wa2, wa3, wa4, wa5, wa6;
  logic wok1, wok2, wok3, wok4, wok5, wok6;
  logic [31:0] wd1, wd2, wd3, wd4, wd5, wd6;
  logic [32:0] dx1, dz1;
  logic [63:0] key1;
  logic [63:0] pu2, pv2;
  logic upos2, vpos2;
  logic [32:0] u_c, v_c, vf_c;
  logic [32:0] u3, v3;
  logic [XW-1:0] x4;
  logic [YW-1:0] y4;
  logic [CW-1:0] x0_c, x1_c;
  logic [RW-1:0] y0_c, y1_c;
  logic [CW-1:0] x0_5, x1_5;
  logic [RW-1:0] y0_5, y1_5;
  logic [15:0] tx5, ty5, tx6, ty6, tx7, ty7, ty8;
  logic [23:0] hv5, hv6, hv7, hv8, hv9, hv10, hv11;
  logic [AW-1:0] base_c, row0_c, row1_c;
  logic [AW-1:0] a00_6, a01_6, a10_6, a11_6;
  logic [31:0] w00_7, w01_7, w10_7, w11_7;
  logic [7:0] b00, b01, b10, b11;
  logic [16:0] ntx, nty;
  logic [23:0] top8, bot8;
  logic [39:0] s9;
  logic [39:0] sr_c;
  logic [31:0] m10, m11;
  logic [56:0] prod11;
  logic [64:0] qsum_c;
  logic [24:0] wsel_c;
  logic keep_c;
  logic keep12, cull12;
  logic [24:0] weight12;
  logic [31:0] cnt, cnt_next;

  logic [31:0] mem_top [MEM_DEPTH];
  logic [31:0] mem_bot [MEM_DEPTH];

  assign cfg_ready = 1'b1;
  assign item_stall = !rdy[1];
  assign result_valid = v[NS];
  assign culled_count = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min_x <= '0;
      range_min_z <= '0;
      inv_span_x <= 32'd65536;
      inv_span_z <= 32'd65536;
      flip_v <= 1'b0;
      image_width <= 8'd128;
      image_height <= 8'd128;
      generated_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RANGE_MIN_X: range_min_x <= cfg_data;
        CFG_RANGE_MIN_Z: range_min_z <= cfg_data;
        CFG_INV_SPAN_X: inv_span_x <= cfg_data;
        CFG_INV_SPAN_Z: inv_span_z <= cfg_data;
        CFG_FLIP_V: flip_v <= cfg_data[0];
        CFG_IMAGE_WIDTH: image_width <= cfg_data[7:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[7:0];
        CFG_GENERATED_COUNT: generated_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == 8'd0) begin
      w_full = 32'd1;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_full = 32'(MAX_WIDTH);
    end else begin
      w_full = 32'(image_width);
    end
    if (image_height == 8'd0) begin
      h_full = 32'd1;
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_full = 32'(MAX_HEIGHT);
    end else begin
      h_full = 32'(image_height);
    end
    wm1 = CW'(w_full - 32'd1);
    hm1 = RW'(h_full - 32'd1);
  end

  always_comb begin
    rdy[NS] = !v[NS] || !result_stall;
    for (int i = NS - 1; i >= 1; i--) begin
      rdy[i] = !v[i] || rdy[i + 1];
    end
    fen.s2 = rdy[2];
    fen.s3 = rdy[3];
    fen.s4 = rdy[4];
    fen.s5 = rdy[5];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= item_valid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i - 1];
        end
      end
    end
  end

  wmsc_fmix u_fmix (
    .clk(clk),
    .en(fen),
    .key(key1),
    .hv(hv5)
  );

  always_comb begin
    if (!upos2) begin
      u_c = '0;
    end else if (pu2[63:32] != 32'd0) begin
      u_c = ONE_Q32;
    end else begin
      u_c = {1'b0, pu2[31:0]};
    end
    if (!vpos2) begin
      v_c = '0;
    end else if (pv2[63:32] != 32'd0) begin
      v_c = ONE_Q32;
    end else begin
      v_c = {1'b0, pv2[31:0]};
    end
    vf_c = flip_v ? ONE_Q32 - v_c : v_c;

    x0_c = x4[32 +: CW];
    y0_c = y4[32 +: RW];
    x1_c = ({1'b0, x0_c} + 1'b1 < {1'b0, wm1}) ? x0_c + 1'b1 : wm1;
    y1_c = ({1'b0, y0_c} + 1'b1 < {1'b0, hm1}) ? y0_c + 1'b1 : hm1;

    base_c = AW'(PLANE) * AW'(tag5.layer[3:2]);
    row0_c = AW'(MAX_WIDTH) * AW'(y0_5);
    row1_c = AW'(MAX_WIDTH) * AW'(y1_5);

    b00 = chan_byte(w00_7, tag7.layer[1:0]);
    b01 = chan_byte(w01_7, tag7.layer[1:0]);
    b10 = chan_byte(w10_7, tag7.layer[1:0]);
    b11 = chan_byte(w11_7, tag7.layer[1:0]);
    ntx = 17'h10000 - 17'(tx7);
    nty = 17'h10000 - 17'(ty8);

    sr_c = s9 + ROUND_HALF;
    qsum_c = {1'b0, m11, 32'b0} + 65'(prod11);

    if (tag11.kind == KIND_LOAD) begin
      wsel_c = '0;
    end else if (!tag11.has) begin
      wsel_c = WEIGHT_ONE;
    end else if (32'(tag11.layer[3:2]) < 32'(GROUPS)) begin
      wsel_c = qsum_c[64:40];
    end else begin
      wsel_c = '0;
    end
    keep_c = (tag11.kind == KIND_TEST) && ({1'b0, hv11} < wsel_c);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      tag1 <= '{kind: kind, has: has_layer, layer: layer_index};
      wa1 <= AW'(texel_address);
      wok1 <= 32'(texel_address) < 32'(MEM_DEPTH);
      wd1 <= texel_data;
      dx1 <= {pos_x[31], pos_x} - {range_min_x[31], range_min_x};
      dz1 <= {pos_z[31], pos_z} - {range_min_z[31], range_min_z};
      key1 <= instance_id ^ {instance_seed, 32'b0} ^ 64'(layer_index);
    end
    if (rdy[2]) begin
      tag2 <= tag1;
      wa2 <= wa1;
      wok2 <= wok1;
      wd2 <= wd1;
      pu2 <= dx1[31:0] * inv_span_x;
      pv2 <= dz1[31:0] * inv_span_z;
      upos2 <= !dx1[32] && (dx1 != 33'd0);
      vpos2 <= !dz1[32] && (dz1 != 33'd0);
    end
    if (rdy[3]) begin
      tag3 <= tag2;
      wa3 <= wa2;
      wok3 <= wok2;
      wd3 <= wd2;
      u3 <= u_c;
      v3 <= vf_c;
    end
    if (rdy[4]) begin
      tag4 <= tag3;
      wa4 <= wa3;
      wok4 <= wok3;
      wd4 <= wd3;
      x4 <= u3 * wm1;
      y4 <= v3 * hm1;
    end
    if (rdy[5]) begin
      tag5 <= tag4;
      wa5 <= wa4;
      wok5 <= wok4;
      wd5 <= wd4;
      x0_5 <= x0_c;
      x1_5 <= x1_c;
      y0_5 <= y0_c;
      y1_5 <= y1_c;
      tx5 <= x4[31:16];
      ty5 <= y4[31:16];
    end
    if (rdy[6]) begin
      tag6 <= tag5;
      wa6 <= wa5;
      wok6 <= wok5;
      wd6 <= wd5;
      a00_6 <= base_c + row0_c + AW'(x0_5);
      a01_6 <= base_c + row0_c + AW'(x1_5);
      a10_6 <= base_c + row1_c + AW'(x0_5);
      a11_6 <= base_c + row1_c + AW'(x1_5);
      tx6 <= tx5;
      ty6 <= ty5;
      hv6 <= hv5;
    end
    if (rdy[7]) begin
      tag7 <= tag6;
      tx7 <= tx6;
      ty7 <= ty6;
      hv7 <= hv6;
    end
    if (rdy[8]) begin
      tag8 <= tag7;
      ty8 <= ty7;
      hv8 <= hv7;
      top8 <= b00 * ntx + b01 * tx7;
      bot8 <= b10 * ntx + b11 * tx7;
    end
    if (rdy[9]) begin
      tag9 <= tag8;
      hv9 <= hv8;
      s9 <= top8 * nty + bot8 * ty8;
    end
    if (rdy[10]) begin
      tag10 <= tag9;
      hv10 <= hv9;
      m10 <= sr_c[39:8];
    end
    if (rdy[11]) begin
      tag11 <= tag10;
      hv11 <= hv10;
      m11 <= m10;
      prod11 <= m10 * RECIP_255_LO;
    end
    if (rdy[12]) begin
      keep12 <= keep_c;
      weight12 <= wsel_c;
      cull12 <= (tag11.kind == KIND_TEST) && !keep_c;
    end
    if (rdy[NS]) begin
      keep <= keep12;
      weight <= weight12;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      if (v[6] && tag6.kind == KIND_LOAD && wok6) begin
        mem_top[wa6] <= wd6;
        mem_bot[wa6] <= wd6;
      end
      w00_7 <= mem_top[a00_6];
      w01_7 <= mem_top[a01_6];
      w10_7 <= mem_bot[a10_6];
      w11_7 <= mem_bot[a11_6];
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (v[12] && cull12 && cnt != 32'hffffffff) begin
      cnt_next = cnt + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      over_budget <= 1'b0;
    end else if (rdy[NS]) begin
      cnt <= cnt_next;
      over_budget <= cnt_next > generated_count;
    end
  end

endmodule

`default_nettype wire

// ----- sv/wmsc_fmix.sv -----
// ----------------------------------------------------------------------------
// wmsc_fmix
// Four-stage 64-bit finalizer mix; each 64-bit multiply is split into
// 32-bit partial products and summed in the following stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wmsc_fmix import wmsc_pkg::*; (
  input  logic        clk,
  input  fmix_en_t    en,
  input  logic [63:0] key,
  output logic [23:0] hv
);

  logic [63:0] h0;
  logic [63:0] p1_lo;
  logic [31:0] p1_x;
  logic [31:0] p1_y;
  logic [63:0] sum1;
  logic [63:0] h1;
  logic [63:0] p2_lo;
  logic [31:0] p2_x;
  logic [31:0] p2_y;
  logic [63:0] sum2;
  logic [63:0] h2;

  always_comb begin
    h0 = key ^ (key >> 33);
    sum1 = p1_lo + {p1_x + p1_y, 32'b0};
    sum2 = p2_lo + {p2_x + p2_y, 32'b0};
    h2 = sum2 ^ (sum2 >> 33);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p1_lo <= h0[31:0] * FMIX_C1[31:0];
      p1_x <= h0[31:0] * FMIX_C1[63:32];
      p1_y <= h0[63:32] * FMIX_C1[31:0];
    end
    if (en.s3) begin
      h1 <= sum1 ^ (sum1 >> 33);
    end
    if (en.s4) begin
      p2_lo <= h1[31:0] * FMIX_C2[31:0];
      p2_x <= h1[31:0] * FMIX_C2[63:32];
      p2_y <= h1[63:32] * FMIX_C2[31:0];
    end
    if (en.s5) begin
      hv <= h2[63:40];
    end
  end

endmodule

`default_nettype wire

// ----- sv/wmsc_chk.sv -----
// ----------------------------------------------------------------------------
// wmsc_chk
// Port-level checks of the weight map stochastic cull unit, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weight_map_stochastic_cull_unit_macros.svh"

module wmsc_chk import wmsc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        keep,
  input logic [24:0] weight,
  input logic [31:0] culled_count
);

  `WMSC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(keep) && $stable(weight) && $stable(culled_count), "stalled result changed")
  `WMSC_ASSERT_IMP(a_keep_needs_weight, result_valid && keep, weight != 25'd0, "kept with zero weight")
  `WMSC_ASSERT_IMP(a_full_weight_kept, result_valid && weight == WEIGHT_ONE, keep, "full weight culled")
  `WMSC_ASSERT_IMP(a_count_monotonic, !$past(rst), culled_count >= $past(culled_count), "cull count fell")

endmodule

bind weight_map_stochastic_cull_unit wmsc_chk u_wmsc_chk (
  .clk(clk),
  .rst(rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .keep(keep),
  .weight(weight),
  .culled_count(culled_count)
);

`default_nettype wire
